[hdl/csoaf_pkg.sv]
// ----------------------------------------------------------------------------
// csoaf_pkg
// Shared widths, codes and reset values for the current sensor offset and
// averaging filter.
// ----------------------------------------------------------------------------
package csoaf_pkg;

  // Field and datapath widths.
  localparam int REQ_W   = 2;
  localparam int RAW_W   = 12;
  localparam int SUP_W   = 13;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int KIND_W  = 2;
  localparam int MV_W    = 17;
  localparam int CUR_W   = 24;
  localparam int SUM_W   = 25;
  localparam int MUL_W   = 17;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int DVD_W   = 25;
  localparam int DVS_W   = 16;
  localparam int SCALE_W = RAW_W + SUP_W + 4;

  // Default module parameters.
  localparam int SAMPLES_DEF  = 16;
  localparam int ADC_BITS_DEF = 12;

  // Saturation limits.
  localparam logic [MV_W-1:0]  MV_MAX      = 17'h1FFFF;
  localparam logic [DVD_W-1:0] CUR_POS_MAG = 25'h07FFFFF;
  localparam logic [DVD_W-1:0] CUR_NEG_MAG = 25'h0800000;
  localparam logic [CUR_W-1:0] CUR_POS_SAT = 24'h7FFFFF;
  localparam logic [CUR_W-1:0] CUR_NEG_SAT = 24'h800000;

  // Request types.
  localparam logic [REQ_W-1:0] REQ_CAL  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MEAS = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FILT = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_OFFSET = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MEAS   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILT   = 2'd2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_SUPPLY = 2'd0;
  localparam logic [IDX_W-1:0] REG_SENS   = 2'd1;
  localparam logic [IDX_W-1:0] REG_ALPHA  = 2'd2;

  // Configuration reset values.
  localparam logic [SUP_W-1:0] SUPPLY_RST = 13'd3300;
  localparam logic [CFG_W-1:0] SENS_RST   = 16'd528;
  localparam logic [CFG_W-1:0] ALPHA_RST  = 16'd6554;

endpackage

[hdl/csoaf_mul.sv]
// ----------------------------------------------------------------------------
// csoaf_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module csoaf_mul #(
  parameter int A_W = csoaf_pkg::MUL_W,
  parameter int B_W = csoaf_pkg::MUL_W
) (
  input  logic               clk,
  input  logic [A_W-1:0]     mul_a,
  input  logic [B_W-1:0]     mul_b,
  output logic [A_W+B_W-1:0] mul_p
);

  // One product per cycle, registered before any further use.
  always_ff @(posedge clk) begin
    mul_p <= (A_W+B_W)'(mul_a) * (A_W+B_W)'(mul_b);
  end

endmodule

[hdl/csoaf_div.sv]
// ----------------------------------------------------------------------------
// csoaf_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csoaf_div #(
  parameter int DVD_W = csoaf_pkg::DVD_W,
  parameter int DVS_W = csoaf_pkg::DVS_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] trial;
  logic             ge;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    rem_sh = {rem, quotient[DVD_W-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dvs};
    ge     = !trial[DVS_W+1];
  end

  // The quotient register starts as the dividend and fills from the bottom.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(DVD_W);
        quotient <= dividend;
        rem      <= '0;
        dvs      <= divisor;
      end else if (busy) begin
        quotient <= {quotient[DVD_W-2:0], ge};
        rem      <= ge ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[hdl/current_sensor_offset_average_filter.sv]
// ----------------------------------------------------------------------------
// current_sensor_offset_average_filter
// Hall current sensor offset calibration, block averaging and exponential
// filtering, built around one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
// The block takes one beat at a time and drops in_ready until that beat is
// fully worked. A calibrate or measure sample that does not end its run is
// scaled and summed. The samples that end a calibrate or a measure run
// also wait for the 25-bit serial divider, which runs once for the average
// and, for a measurement, once more for the division by the sensitivity. A
// filter sample takes three passes through the shared multiplier and one
// divider run. Request type three is dropped with no result.
// A finished result waits in the output register while the next input beat is
// already accepted; a second result waits in the sequencer until the first
// one is taken.
// ----------------------------------------------------------------------------
module current_sensor_offset_average_filter #(
  parameter int SAMPLES  = csoaf_pkg::SAMPLES_DEF,
  parameter int ADC_BITS = csoaf_pkg::ADC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [csoaf_pkg::IDX_W-1:0]         cfg_index,
  input  logic [csoaf_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [csoaf_pkg::REQ_W-1:0]         req_type,
  input  logic [csoaf_pkg::RAW_W-1:0]         adc_raw,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [csoaf_pkg::KIND_W-1:0]        result_kind,
  output logic signed [csoaf_pkg::CUR_W-1:0]  current_q8,
  output logic [csoaf_pkg::MV_W-1:0]          offset_mv_q4,
  output logic [csoaf_pkg::MV_W-1:0]          filtered_mv_q4
);

  import csoaf_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES + 1);
  localparam int ST_W  = 4;

  localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
  localparam logic [ST_W-1:0] S_SCALE   = 4'd1;
  localparam logic [ST_W-1:0] S_SAMPLE  = 4'd2;
  localparam logic [ST_W-1:0] S_FILT_A  = 4'd3;
  localparam logic [ST_W-1:0] S_FILT_B  = 4'd4;
  localparam logic [ST_W-1:0] S_FILT_C  = 4'd5;
  localparam logic [ST_W-1:0] S_DIV_AVG = 4'd6;
  localparam logic [ST_W-1:0] S_DIV_CUR = 4'd7;
  localparam logic [ST_W-1:0] S_OUT     = 4'd8;

  logic [ST_W-1:0]   state;
  logic [REQ_W-1:0]  req;
  logic [RAW_W-1:0]  raw;
  logic [MV_W-1:0]   mv;
  logic [CNT_W-1:0]  sample_count;
  logic [SUM_W-1:0]  run_sum;
  logic [REQ_W-1:0]  run_kind;
  logic [MV_W-1:0]   offset_level;
  logic [MV_W-1:0]   filter_level;
  logic [ACC_W-1:0]  acc;
  logic              neg;
  logic [KIND_W-1:0] kind;
  logic [SUP_W-1:0]  supply_mv;
  logic [CFG_W-1:0]  sensitivity_q4;
  logic [CFG_W-1:0]  alpha_q16;

  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic               div_start;
  logic [DVD_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic               div_done;
  logic [DVD_W-1:0]   div_quo;

  logic [SCALE_W-1:0] scaled;
  logic [MV_W-1:0]    mv_calc;
  logic               restart;
  logic [CNT_W-1:0]   count_inc;
  logic [SUM_W-1:0]   sum_add;
  logic               run_done;
  logic [ACC_W-1:0]   filt_sum;
  logic [MV_W+1:0]    filt_shift;
  logic [MV_W-1:0]    filt_new;
  logic [MV_W-1:0]    filt_delta;
  logic [MV_W-1:0]    avg;
  logic [MV_W:0]      meas_diff;
  logic               meas_neg;
  logic [MV_W-1:0]    meas_mag;
  logic [DVS_W-1:0]   sens_div;
  logic [CUR_W-1:0]   cur_sat;

  csoaf_mul #(.A_W(MUL_W), .B_W(MUL_W)) u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  csoaf_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ready = (state == S_IDLE);

  // Sample scaling to sixteenths of a millivolt, and the run bookkeeping.
  always_comb begin
    scaled    = {mul_p[RAW_W+SUP_W-1:0], 4'b0000} >> ADC_BITS;
    mv_calc   = (scaled > SCALE_W'(MV_MAX)) ? MV_MAX : scaled[MV_W-1:0];
    restart   = (req != run_kind);
    count_inc = (restart ? '0 : sample_count) + 1'b1;
    sum_add   = (restart ? '0 : run_sum) + SUM_W'(mv_calc);
    run_done  = (count_inc == CNT_W'(SAMPLES));
  end

  // Filter update and the differences that feed the current conversion.
  always_comb begin
    filt_sum   = acc + {1'b0, mul_p};
    filt_shift = filt_sum[ACC_W-1:16];
    filt_new   = (|filt_shift[MV_W+1:MV_W]) ? MV_MAX : filt_shift[MV_W-1:0];
    filt_delta = (filt_new > offset_level) ? (filt_new - offset_level) : '0;
    avg        = (|div_quo[DVD_W-1:MV_W]) ? MV_MAX : div_quo[MV_W-1:0];
    meas_diff  = {1'b0, avg} - {1'b0, offset_level};
    meas_neg   = meas_diff[MV_W];
    meas_mag   = meas_neg ? MV_W'((MV_W+1)'(0) - meas_diff) : meas_diff[MV_W-1:0];
    sens_div   = (sensitivity_q4 == '0) ? DVS_W'(1) : sensitivity_q4;
  end

  // Saturate the signed quotient to the 24-bit current range.
  always_comb begin
    if (neg) begin
      cur_sat = (div_quo > CUR_NEG_MAG) ? CUR_NEG_SAT : CUR_W'(DVD_W'(0) - div_quo);
    end else begin
      cur_sat = (div_quo > CUR_POS_MAG) ? CUR_POS_SAT : div_quo[CUR_W-1:0];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state)
      S_FILT_A: begin
        mul_a = MUL_W'(18'h10000 - {2'b00, alpha_q16});
        mul_b = filter_level;
      end
      S_FILT_B: begin
        mul_a = MUL_W'(alpha_q16);
        mul_b = mv;
      end
      default: begin
        mul_a = MUL_W'(raw);
        mul_b = MUL_W'(supply_mv);
      end
    endcase
  end

  // Divider launches: run average, then current from the delta.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {filt_delta, 8'h00};
    div_divisor  = sens_div;
    unique case (state)
      S_SAMPLE: begin
        if (req != REQ_FILT && run_done) begin
          div_start    = 1'b1;
          div_dividend = sum_add;
          div_divisor  = DVS_W'(SAMPLES);
        end
      end
      S_FILT_C: begin
        div_start = 1'b1;
      end
      S_DIV_AVG: begin
        if (div_done && req == REQ_MEAS) begin
          div_start    = 1'b1;
          div_dividend = {meas_mag, 8'h00};
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      supply_mv      <= SUPPLY_RST;
      sensitivity_q4 <= SENS_RST;
      alpha_q16      <= ALPHA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SUPPLY: supply_mv      <= cfg_data[SUP_W-1:0];
        REG_SENS:   sensitivity_q4 <= cfg_data;
        REG_ALPHA:  alpha_q16      <= cfg_data;
        default:    supply_mv      <= supply_mv;
      endcase
    end
  end

  // Sequencer, run state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_count <= '0;
      run_sum      <= '0;
      run_kind     <= REQ_CAL;
      offset_level <= '0;
      filter_level <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= req_type;
            raw <= adc_raw;
            if (req_type != REQ_NONE) begin
              state <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          state <= S_SAMPLE;
        end
        S_SAMPLE: begin
          mv       <= mv_calc;
          run_kind <= req;
          if (req == REQ_FILT) begin
            if (restart) begin
              sample_count <= '0;
              run_sum      <= '0;
            end
            state <= S_FILT_A;
          end else if (run_done) begin
            sample_count <= '0;
            run_sum      <= '0;
            state        <= S_DIV_AVG;
          end else begin
            sample_count <= count_inc;
            run_sum      <= sum_add;
            state        <= S_IDLE;
          end
        end
        S_FILT_A: begin
          state <= S_FILT_B;
        end
        S_FILT_B: begin
          acc   <= {1'b0, mul_p};
          state <= S_FILT_C;
        end
        S_FILT_C: begin
          filter_level <= filt_new;
          kind         <= KIND_FILT;
          neg          <= 1'b0;
          state        <= S_DIV_CUR;
        end
        S_DIV_AVG: begin
          if (div_done) begin
            if (req == REQ_CAL) begin
              offset_level <= avg;
              kind         <= KIND_OFFSET;
              state        <= S_OUT;
            end else begin
              kind  <= KIND_MEAS;
              neg   <= meas_neg;
              state <= S_DIV_CUR;
            end
          end
        end
        S_DIV_CUR: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            result_kind    <= kind;
            current_q8     <= (kind == KIND_OFFSET) ? '0 : cur_sat;
            offset_mv_q4   <= offset_level;
            filtered_mv_q4 <= filter_level;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/sv/current_sensor_offset_average_filter_tb.sv]
// ----------------------------------------------------------------------------
// current_sensor_offset_average_filter_tb
// Self-checking bench for the current sensor offset and averaging filter.
// A scoreboard class mirrors the offset calibration, block averaging and
// exponential filter in fixed point and checks every reading against it.
// Stimulus is a short directed sequence, then phases of mostly complete runs
// with random content under changing register settings, idle and stall
// patterns, and one long output hold-off.
// ----------------------------------------------------------------------------
module current_sensor_offset_average_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csoaf_pkg::*;

  localparam longint AMPS_MAX       = 8388607;
  localparam longint AMPS_MIN       = -8388608;
  localparam int     PHASES         = 8;
  localparam int     PHASE_ITEMS    = 154;
  localparam int     PRESSURE_PHASE = 4;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     SETTLE_CYCLES  = 100;
  localparam int     WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CUR_W-1:0]  amps;
    logic [MV_W-1:0]   offset;
    logic [MV_W-1:0]   filt;
  } reading_t;

  // Scoreboard: mirrors the sensor math and holds the readings still due.
  class sensor_scoreboard;
    logic [SUP_W-1:0] supply;
    logic [CFG_W-1:0] sensitivity;
    logic [CFG_W-1:0] alpha;
    int unsigned      run_count;
    logic [SUM_W-1:0] run_sum;
    logic [REQ_W-1:0] run_req;
    logic [MV_W-1:0]  offset_level;
    logic [MV_W-1:0]  filt_level;
    reading_t         expected_readings[$];
    int               errors;
    int               samples;
    int               kind_count[3];

    function new();
      supply       = SUPPLY_RST;
      sensitivity  = SENS_RST;
      alpha        = ALPHA_RST;
      run_count    = 0;
      run_sum      = '0;
      run_req      = REQ_CAL;
      offset_level = '0;
      filt_level   = '0;
      errors       = 0;
      samples      = 0;
      kind_count   = '{0, 0, 0};
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SUPPLY: supply = data[SUP_W-1:0];
        REG_SENS:   sensitivity = data;
        REG_ALPHA:  alpha = data;
        default: ;
      endcase
    endfunction

    // Millivolt difference to amperes in Q8, truncated toward zero.
    function logic [CUR_W-1:0] amps_q8(longint delta);
      longint divisor;
      longint q;
      divisor = (sensitivity == 0) ? 1 : longint'(sensitivity);
      q = (delta * 256) / divisor;
      if (q > AMPS_MAX) q = AMPS_MAX;
      if (q < AMPS_MIN) q = AMPS_MIN;
      return q[CUR_W-1:0];
    endfunction

    // Work out what one accepted input beat produces, if anything.
    function void note_sample(logic [REQ_W-1:0] req, logic [RAW_W-1:0] raw);
      longint unsigned mv;
      longint unsigned a;
      longint unsigned f;
      longint unsigned avg;
      reading_t r;
      samples++;
      if (req == REQ_NONE) return;
      mv = raw;
      mv = (mv * supply * 16) >> ADC_BITS_DEF;
      if (mv > MV_MAX) mv = MV_MAX;
      // A new request type starts a fresh run.
      if (req != run_req) begin
        run_count = 0;
        run_sum   = '0;
        run_req   = req;
      end
      if (req == REQ_FILT) begin
        a = alpha;
        f = ((65536 - a) * filt_level + a * mv) >> 16;
        filt_level = (f > MV_MAX) ? MV_MAX : f[MV_W-1:0];
        r.kind = KIND_FILT;
        r.amps = amps_q8(filt_level > offset_level ?
                         longint'(filt_level) - longint'(offset_level) : 0);
      end else begin
        run_sum = run_sum + mv[SUM_W-1:0];
        run_count++;
        if (run_count < SAMPLES_DEF) return;
        avg = run_sum / SAMPLES_DEF;
        if (avg > MV_MAX) avg = MV_MAX;
        run_count = 0;
        run_sum   = '0;
        if (req == REQ_CAL) begin
          offset_level = avg[MV_W-1:0];
          r.kind = KIND_OFFSET;
          r.amps = '0;
        end else begin
          r.kind = KIND_MEAS;
          r.amps = amps_q8(longint'(avg) - longint'(offset_level));
        end
      end
      r.offset = offset_level;
      r.filt   = filt_level;
      expected_readings.push_back(r);
    endfunction

    function void match_field(string name, logic [CUR_W-1:0] want, logic [CUR_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
    endfunction

    // Compare one reading from the block with the oldest one due.
    function void check_reading(reading_t got);
      reading_t want;
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t: reading with none due, expected nothing actual %h", $time, got);
        return;
      end
      want = expected_readings.pop_front();
      if (got.kind <= KIND_FILT) kind_count[got.kind]++;
      match_field("result_kind", want.kind, got.kind);
      match_field("current_q8", want.amps, got.amps);
      match_field("offset_mv_q4", want.offset, got.offset);
      match_field("filtered_mv_q4", want.filt, got.filt);
    endfunction
  endclass

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     cfg_we    = 1'b0;
  logic [IDX_W-1:0]         cfg_index = REG_SUPPLY;
  logic [CFG_W-1:0]         cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [REQ_W-1:0]         req_type  = REQ_CAL;
  logic [RAW_W-1:0]         adc_raw   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [KIND_W-1:0]        result_kind;
  logic signed [CUR_W-1:0]  current_q8;
  logic [MV_W-1:0]          offset_mv_q4;
  logic [MV_W-1:0]          filtered_mv_q4;

  sensor_scoreboard sb;
  int       send_idle_pct = 0;
  int       stall_pct     = 0;
  bit       hold_req      = 1'b0;
  int       hold_left     = 0;
  int       quiet         = 0;
  int       sent_items    = 0;
  int       settings      = 1;
  reading_t seen;

  current_sensor_offset_average_filter u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .adc_raw       (adc_raw),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .current_q8    (current_q8),
    .offset_mv_q4  (offset_mv_q4),
    .filtered_mv_q4(filtered_mv_q4)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off counted here when requested.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor both channels and watch for a stuck run.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_sample(req_type, adc_raw);
      if (out_valid && out_ready) begin
        seen.kind   = result_kind;
        seen.amps   = current_q8;
        seen.offset = offset_mv_q4;
        seen.filt   = filtered_mv_q4;
        sb.check_reading(seen);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Offer one input beat, after an optional idle gap, and wait until it is taken.
  task automatic send_beat(input logic [REQ_W-1:0] req, input logic [RAW_W-1:0] raw);
    int gap;
    gap = 0;
    if (send_idle_pct > 0)
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    adc_raw  <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req != REQ_NONE) sent_items++;
  endtask

  // Stop offering, wait for every reading due, then let the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_readings.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [SUP_W-1:0] sup, input logic [CFG_W-1:0] sens,
                              input logic [CFG_W-1:0] alpha);
    logic [IDX_W-1:0] idxs [3];
    logic [CFG_W-1:0] vals [3];
    idxs = '{REG_SUPPLY, REG_SENS, REG_ALPHA};
    vals = '{{3'b000, sup}, sens, alpha};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Run level: often a rail, otherwise anywhere in range.
  function automatic logic [RAW_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return RAW_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] jitter(input logic [RAW_W-1:0] level);
    int v;
    if (level == '0 || level == '1) return level;
    v = int'(level) + $urandom_range(0, 32) - 16;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return RAW_W'(v);
  endfunction

  // Mostly complete runs and filter bursts, with broken runs and noise mixed in.
  task automatic run_traffic(input int target);
    int stop_at;
    int pick;
    int len;
    logic [REQ_W-1:0] req;
    logic [RAW_W-1:0] level;
    stop_at = sent_items + target;
    while (sent_items < stop_at) begin
      pick  = $urandom_range(0, 99);
      req   = $urandom_range(0, 1) ? REQ_MEAS : REQ_CAL;
      level = pick_level();
      if (pick < 35) begin
        for (int i = 0; i < SAMPLES_DEF; i++) send_beat(req, jitter(level));
      end else if (pick < 60) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) send_beat(REQ_FILT, jitter(level));
      end else if (pick < 78) begin
        len = $urandom_range(1, SAMPLES_DEF - 1);
        for (int i = 0; i < len; i++) send_beat(req, jitter(level));
      end else if (pick < 88) begin
        send_beat(REQ_NONE, RAW_W'($urandom_range(0, 4095)));
      end else begin
        send_beat(REQ_W'($urandom_range(0, 3)), RAW_W'($urandom_range(0, 4095)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on reset settings: ignored type, filter rails, broken
    // runs, a full calibration at full scale, then a filter below the offset.
    send_beat(REQ_NONE, '1);
    send_beat(REQ_FILT, '1);
    send_beat(REQ_FILT, '0);
    repeat (3) send_beat(REQ_CAL, '1);
    send_beat(REQ_MEAS, '0);
    repeat (SAMPLES_DEF) send_beat(REQ_CAL, '1);
    send_beat(REQ_FILT, '0);
    settle();

    // Random phases, each with its own settings and idle pattern.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      case (ph)
        0: write_config(13'd5000, 16'd1, 16'd65535);
        1: write_config(13'd1, 16'd65535, 16'd0);
        3: write_config(13'd3300, 16'd0, 16'd32768);
        default: write_config(SUP_W'($urandom_range(1, 5000)),
                              CFG_W'($urandom_range(0, 1) ? $urandom_range(1, 600)
                                                          : $urandom_range(1, 65535)),
                              CFG_W'($urandom_range(0, 65535)));
      endcase
      if (ph == PRESSURE_PHASE) hold_req = 1'b1;
      run_traffic(PHASE_ITEMS);
      settle();
    end

    $display("Checked %0d input beats and %0d readings: %0d offsets, %0d averages, %0d filtered",
             sb.samples, sb.kind_count[0] + sb.kind_count[1] + sb.kind_count[2],
             sb.kind_count[0], sb.kind_count[1], sb.kind_count[2]);
    $display("Ran %0d register settings with idle, stall and hold-off phases, %0d errors",
             settings, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
